@@ rtl/core/ttwg_pkg.sv @@
package ttwg_pkg;

   // field widths
   localparam int unsigned POT_W      = 14;
   localparam int unsigned THR_W      = 16;
   localparam int unsigned HALF_W     = 24;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   // one quotient bit per divider step
   localparam int unsigned DIV_STEPS  = THR_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [THR_W-1:0] THR_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TICKS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_HIGH  = 3'd4;

   // reset values
   localparam logic [HALF_W-1:0] RAMP_TICKS_RST = 24'd20480;
   localparam logic [HALF_W-1:0] STEP_TICKS_RST = 24'd512;
   localparam logic [THR_W-1:0]  STEP_LOW_RST   = 16'd39322;
   localparam logic [THR_W-1:0]  STEP_HIGH_RST  = 16'd45875;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_MANUAL = 2'd1,
      MODE_RAMP   = 2'd2,
      MODE_STEP   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

endpackage

@@ rtl/core/ttwg_ctrl.sv @@
module ttwg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ttwg_pkg::status_type status,
   output ttwg_pkg::cmd_type    cmd
);

   localparam logic [ttwg_pkg::DIV_CNT_W-1:0] CNT_LAST =
      ttwg_pkg::DIV_CNT_W'(ttwg_pkg::DIV_STEPS - 1);

   ttwg_pkg::state_type               state_ff, state_in;
   logic [ttwg_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ttwg_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = '0;
      cmd.accept   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ttwg_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.need_div ? ttwg_pkg::ST_DIV : ttwg_pkg::ST_DONE;
            end
         end
         ttwg_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = ttwg_pkg::ST_DONE;
            end
         end
         ttwg_pkg::ST_DONE: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ttwg_pkg::ST_IDLE;
            end
         end
         default: state_in = ttwg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttwg_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_cnt_only_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ttwg_pkg::ST_DIV) |-> (cnt_ff == '0))
      else $error("divider step count left over outside division");

   a_div_ends_in_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ttwg_pkg::ST_DIV && cnt_ff == CNT_LAST) |=> (state_ff == ttwg_pkg::ST_DONE))
      else $error("division did not finish after the last step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ttwg_pkg::ST_DONE))
      else $error("result raised outside the done state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff != ttwg_pkg::ST_IDLE))
      else $error("accepted transaction did not start work");
`endif

endmodule

@@ rtl/core/ttwg_dpath.sv @@
module ttwg_dpath #(
   parameter int unsigned TICK_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [ttwg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ttwg_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic [ttwg_pkg::POT_W-1:0]         req_pot_sum,
   input  ttwg_pkg::cmd_type                  cmd,
   output ttwg_pkg::status_type               status,
   output logic [ttwg_pkg::THR_W-1:0]         rsp_throttle
);

   localparam int unsigned HW = ttwg_pkg::HALF_W;
   localparam int unsigned TW = ttwg_pkg::THR_W;

   // configuration
   ttwg_pkg::mode_type   mode_ff;
   logic [HW-1:0]        ramp_ff, step_ff;
   logic [TW-1:0]        low_ff, high_ff;

   // tick count and arithmetic
   logic [TICK_BITS-1:0] e_ff, e_in, e_base;
   logic [HW-1:0]        rem_ff, rem_in;
   logic [TW-1:0]        res_ff, res_in;
   logic [TW-1:0]        thr_ff;

   logic [TICK_BITS-1:0] d_ext, d2_ext, s_ext, s2_ext, n_hi;
   logic                 ramp_lo, ramp_in_cycle, step_lo, step_in_cycle;
   logic                 restart, peak;
   logic [HW-1:0]        num;
   logic [TW-1:0]        direct;
   logic [HW:0]          trial;
   logic                 fits;

   assign d_ext  = TICK_BITS'(ramp_ff);
   assign d2_ext = TICK_BITS'({ramp_ff, 1'b0});
   assign s_ext  = TICK_BITS'(step_ff);
   assign s2_ext = TICK_BITS'({step_ff, 1'b0});

   assign ramp_lo       = e_ff < d_ext;
   assign ramp_in_cycle = e_ff < d2_ext;
   assign step_lo       = e_ff < s_ext;
   assign step_in_cycle = e_ff < s2_ext;

   // falling half: 2D - E, never above D
   assign n_hi = d2_ext - e_ff;
   assign num  = ramp_lo ? e_ff[HW-1:0] : n_hi[HW-1:0];
   assign peak = (num == ramp_ff);

   always_comb begin
      restart = 1'b0;
      direct  = '0;
      unique case (mode_ff)
         ttwg_pkg::MODE_IDLE:   direct = '0;
         ttwg_pkg::MODE_MANUAL: direct = {req_pot_sum, 2'b00};
         ttwg_pkg::MODE_RAMP: begin
            restart = !ramp_in_cycle;
            direct  = (!restart && peak) ? ttwg_pkg::THR_MAX : '0;
         end
         ttwg_pkg::MODE_STEP: begin
            restart = !step_in_cycle;
            direct  = (step_lo || restart) ? low_ff : high_ff;
         end
         default: direct = '0;
      endcase
   end

   assign status.need_div = (mode_ff == ttwg_pkg::MODE_RAMP) && ramp_in_cycle && !peak;

   // count runs every tick, restart marks it to zero first
   assign e_base = restart ? '0 : e_ff;
   assign e_in   = (&e_base) ? e_base : e_base + 1'b1;

   // restoring division, remainder stays below D
   assign trial = {rem_ff, 1'b0};
   assign fits  = trial >= {1'b0, ramp_ff};

   always_comb begin
      rem_in = rem_ff;
      res_in = res_ff;
      if (cmd.accept) begin
         rem_in = num;
         res_in = direct;
      end else if (cmd.div_step) begin
         rem_in = fits ? HW'(trial - {1'b0, ramp_ff}) : trial[HW-1:0];
         res_in = {res_ff[TW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ttwg_pkg::MODE_IDLE;
         ramp_ff <= ttwg_pkg::RAMP_TICKS_RST;
         step_ff <= ttwg_pkg::STEP_TICKS_RST;
         low_ff  <= ttwg_pkg::STEP_LOW_RST;
         high_ff <= ttwg_pkg::STEP_HIGH_RST;
         e_ff    <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               ttwg_pkg::CSR_MODE:       mode_ff <= ttwg_pkg::mode_type'(csr_data[1:0]);
               ttwg_pkg::CSR_RAMP_TICKS: ramp_ff <= csr_data[HW-1:0];
               ttwg_pkg::CSR_STEP_TICKS: step_ff <= csr_data[HW-1:0];
               ttwg_pkg::CSR_STEP_LOW:   low_ff  <= csr_data[TW-1:0];
               ttwg_pkg::CSR_STEP_HIGH:  high_ff <= csr_data[TW-1:0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            e_ff <= e_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      if (cmd.load_out) begin
         thr_ff <= res_ff;
      end
   end

   assign rsp_throttle = thr_ff;

endmodule

@@ rtl/core/throttle_test_waveform_generator.sv @@
// throttle test waveform generator
// each req transaction is one periodic tick carrying the summed pot reading
// (req_pot_sum); each tick yields exactly one rsp transaction with the
// throttle command rsp_throttle as an unsigned 0.16 fraction
// modes come from the csr channel: idle, manual (pot scaled to full range),
// ramp (triangle of half period ramp_ticks) and step (square wave between
// step_low and step_high with half period step_ticks)
// csr writes are taken every cycle (csr_ready is tied high) and must only
// happen while no tick is in flight
// manual, idle, step and the ramp restart and peak go from accept to the
// done state and into the output register; the ramp slopes pass the divide
// state first, as a restoring divider makes the quotient one bit per cycle
// one tick is worked on at a time: req_ready is high only while the
// controller is idle, so a new tick waits until the last one is loaded
// a stalled receiver holds the result in the output register; the next tick
// may still be accepted and computed, and waits only to be loaded
// reset (synchronous) restores the register defaults and clears the tick count
module throttle_test_waveform_generator #(
   parameter int unsigned TICK_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // tick channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ttwg_pkg::POT_W-1:0]       req_pot_sum,
   // throttle channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ttwg_pkg::THR_W-1:0]       rsp_throttle,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ttwg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ttwg_pkg::CSR_DATA_W-1:0]  csr_data
);

   ttwg_pkg::cmd_type    cmd;
   ttwg_pkg::status_type status;

   // registers never push back
   assign csr_ready = 1'b1;

   // sequencing: accept, divide, hand off to the output register
   ttwg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // config registers, tick count, waveform select and divider
   ttwg_dpath #(
      .TICK_BITS (TICK_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_pot_sum  (req_pot_sum),
      .cmd          (cmd),
      .status       (status),
      .rsp_throttle (rsp_throttle)
   );

endmodule
